// ----- rtl/mms_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the moving mean-square block.
// No dependencies.
package mms_pkg;

	localparam int LEN_W     = 11;
	localparam int RECIP_W   = 17;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_W     = 31;
	localparam int FRAC_W    = 16;

	localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(1024);
	localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(64);
	localparam logic [OUT_W-1:0]   OUT_MAX     = '1;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RECIPROCAL = CFG_IDX_W'(1);

	typedef struct packed {
		logic advance;
		logic accept;
		logic clear;
	} mms_ctrl_t;

endpackage

// ----- rtl/mms_window.sv -----
`timescale 1ns / 1ps
// Square ring memory, write slot and running sum of squares.
// Depends on mms_pkg.
module mms_window import mms_pkg::*; #(
	parameter int MAX_WINDOW   = 1024,
	parameter int SAMPLE_WIDTH = 16,
	localparam int SLOT_W = $clog2(MAX_WINDOW),
	localparam int SQ_W   = 2 * SAMPLE_WIDTH - 1,
	localparam int SUM_W  = SQ_W + SLOT_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mms_ctrl_t                      ctrl,
	input  logic        [LEN_W-1:0]        window_length,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic        [SUM_W-1:0]        sum_s2,
	output logic                           valid_s2
);

	logic [SQ_W-1:0]           mem [MAX_WINDOW];
	logic [SLOT_W-1:0]         slot_q;
	logic                      wrapped_q;
	logic [SUM_W-1:0]          sum_q;
	logic                      valid_s1;
	logic [SQ_W-1:0]           sq_s1;
	logic [SQ_W-1:0]           old_s1;
	logic                      seen_s1;

	logic [SAMPLE_WIDTH-1:0]   mag;
	logic [2*SAMPLE_WIDTH-1:0] sq_full;
	logic [SQ_W-1:0]           sq;
	logic [31:0]               len_ext;
	logic [31:0]               len_eff;
	logic [31:0]               last_slot;
	logic                      wrap;
	logic [SQ_W-1:0]           old_eff;
	logic [SUM_W-1:0]          sum_next;

	always_comb begin
		mag = sample[SAMPLE_WIDTH-1] ? (~unsigned'(sample) + SAMPLE_WIDTH'(1))
			: unsigned'(sample);
		sq_full = (2*SAMPLE_WIDTH)'(mag) * (2*SAMPLE_WIDTH)'(mag);
		sq = sq_full[SQ_W-1:0];
		len_ext = 32'(window_length);
		if (len_ext == 32'd0) begin
			len_eff = 32'd1;
		end else if (len_ext > 32'(MAX_WINDOW)) begin
			len_eff = 32'(MAX_WINDOW);
		end else begin
			len_eff = len_ext;
		end
		last_slot = len_eff - 32'd1;
		wrap = 32'(slot_q) >= last_slot;
		old_eff = seen_s1 ? old_s1 : '0;
		sum_next = sum_q + SUM_W'(sq_s1) - SUM_W'(old_eff);
	end

	// read-before-write: the read returns the square being replaced
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			old_s1 <= mem[slot_q];
			mem[slot_q] <= sq;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			sq_s1 <= sq;
			seen_s1 <= wrapped_q;
		end
		if (ctrl.advance && valid_s1) begin
			sum_s2 <= sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			wrapped_q <= 1'b0;
			sum_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ctrl.advance) begin
				valid_s1 <= ctrl.accept;
				valid_s2 <= valid_s1;
			end
			if (ctrl.clear) begin
				slot_q <= '0;
				wrapped_q <= 1'b0;
				sum_q <= '0;
			end else begin
				if (ctrl.accept) begin
					slot_q <= wrap ? '0 : slot_q + SLOT_W'(1);
					if (wrap) begin
						wrapped_q <= 1'b1;
					end
				end
				if (ctrl.advance && valid_s1) begin
					sum_q <= sum_next;
				end
			end
		end
	end

endmodule

// ----- rtl/mms_scale.sv -----
`timescale 1ns / 1ps
// Scales the sum of squares by the Q1.16 reciprocal and saturates.
// Depends on mms_pkg.
module mms_scale import mms_pkg::*; #(
	parameter int SUM_W = 41
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               valid_s2,
	input  logic [SUM_W-1:0]   sum_s2,
	input  logic [RECIP_W-1:0] recip,
	output logic               out_valid,
	output logic [OUT_W-1:0]   mean_square
);

	localparam int LO_W  = (SUM_W + 1) / 2;
	localparam int HI_W  = SUM_W - LO_W;
	localparam int PL_W  = LO_W + RECIP_W;
	localparam int PH_W  = HI_W + RECIP_W;
	localparam int TOT_W = SUM_W + RECIP_W;
	localparam int EXT_W = (TOT_W > FRAC_W + OUT_W + 1) ? TOT_W : FRAC_W + OUT_W + 1;

	logic [PL_W-1:0]  p_lo_s3;
	logic [PH_W-1:0]  p_hi_s3;
	logic             valid_s3;
	logic [EXT_W-1:0] total;
	logic [EXT_W-1:0] scaled;
	logic             sat;

	always_comb begin
		total = (EXT_W'(p_hi_s3) << LO_W) + EXT_W'(p_lo_s3);
		scaled = total >> FRAC_W;
		sat = scaled > EXT_W'(OUT_MAX);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			p_lo_s3 <= PL_W'(sum_s2[LO_W-1:0]) * PL_W'(recip);
			p_hi_s3 <= PH_W'(sum_s2[SUM_W-1:LO_W]) * PH_W'(recip);
			if (valid_s3) begin
				mean_square <= sat ? OUT_MAX : scaled[OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
			out_valid <= valid_s3;
		end
	end

endmodule

// ----- rtl/moving_mean_square_top.sv -----
`timescale 1ns / 1ps
// Moving mean-square top level: configuration registers and pipeline control.
// Depends on mms_pkg, mms_window and mms_scale.
//
// Takes one signed sample per cycle and returns, through the s1, s2, s3 and
// output registers, the exact sum of the squares in the window times the Q1.16
// reciprocal, shifted right by 16 and saturated to 31 bits. The squares live
// in a single-port ring memory read and written in the accept cycle; the sum
// register closes its loop directly and the scaling multiply is split in
// two halves over one stage, so the sustained rate is one item per clock.
// All stages hold together while a result waits on a stalled output, and
// in_stall follows that condition. Writing window_length restarts the window:
// ring entries not yet written since the restart read as zero, so no clearing
// sweep of the memory is needed after reset or a restart.
module moving_mean_square_top import mms_pkg::*; #(
	parameter int MAX_WINDOW   = 1024,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic        [CFG_IDX_W-1:0]    cfg_index,
	input  logic        [CFG_W-1:0]        cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic        [OUT_W-1:0]        mean_square
);

	localparam int SUM_W = 2 * SAMPLE_WIDTH - 1 + $clog2(MAX_WINDOW);

	logic [LEN_W-1:0]   window_length_q;
	logic [RECIP_W-1:0] window_reciprocal_q;
	logic               len_write;
	logic               advance;
	mms_ctrl_t          ctrl;
	logic [SUM_W-1:0]   sum_s2;
	logic               valid_s2;

	always_comb begin
		len_write = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: len_write = 1'b1;
				default: len_write = 1'b0;
			endcase
		end
		advance = !out_valid || !out_stall;
		in_stall = !advance;
		ctrl.advance = advance;
		ctrl.accept = in_valid && advance;
		ctrl.clear = len_write;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= LEN_RESET;
			window_reciprocal_q <= RECIP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: window_length_q <= cfg_data[LEN_W-1:0];
				REG_WINDOW_RECIPROCAL: window_reciprocal_q <= cfg_data[RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	mms_window #(
		.MAX_WINDOW(MAX_WINDOW),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.window_length(window_length_q),
		.sample(sample),
		.sum_s2(sum_s2),
		.valid_s2(valid_s2)
	);

	mms_scale #(
		.SUM_W(SUM_W)
	) u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.valid_s2(valid_s2),
		.sum_s2(sum_s2),
		.recip(window_reciprocal_q),
		.out_valid(out_valid),
		.mean_square(mean_square)
	);

endmodule

// ----- rtl/moving_mean_square_chk.sv -----
`timescale 1ns / 1ps
// Port-level checks for the moving mean-square top level, with its bind.
// Depends on mms_pkg and moving_mean_square_top.
module moving_mean_square_chk import mms_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [OUT_W-1:0] mean_square
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mean_square))
		else $error("stalled result changed");

	// stall input only behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// deliver after accept when out_stall stays low through the pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("item did not reach the output in time");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present out of reset");

endmodule

bind moving_mean_square_top moving_mean_square_chk u_chk (.*);

// ----- sim/mean_square_monitor.sv -----
`timescale 1ns / 1ps
// Channel monitor for moving_mean_square_top: tracks register writes, predicts
// the windowed mean square of each accepted sample and compares results in order.
// Depends on mms_pkg.
module mean_square_monitor import mms_pkg::*; #(
	parameter int MAX_WINDOW   = 1024,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic        [CFG_IDX_W-1:0]    cfg_index,
	input  logic        [CFG_W-1:0]        cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic        [OUT_W-1:0]        mean_square,
	output int                             mismatches,
	output int                             outstanding
);

	localparam int SQ_W   = 2 * SAMPLE_WIDTH - 1;
	localparam int SLOT_W = $clog2(MAX_WINDOW);
	localparam int SUM_W  = SQ_W + SLOT_W;
	localparam int PROD_W = SUM_W + RECIP_W;

	logic [SQ_W-1:0]    squares [MAX_WINDOW];
	logic [SLOT_W-1:0]  slot;
	logic [SUM_W-1:0]   square_total;
	logic [LEN_W-1:0]   win_len;
	logic [RECIP_W-1:0] recip;
	logic [OUT_W-1:0]   awaited_means [$];

	task automatic restart_window();
		for (int i = 0; i < MAX_WINDOW; i++)
			squares[i] = '0;
		slot = '0;
		square_total = '0;
	endtask

	task automatic step_window(input logic signed [SAMPLE_WIDTH-1:0] s,
			output logic [OUT_W-1:0] mean);
		logic [SAMPLE_WIDTH:0] ext;
		logic [SQ_W-1:0]       mag;
		logic [SQ_W-1:0]       sq;
		logic [SQ_W-1:0]       old;
		logic [PROD_W-1:0]     prod;
		int                    span;
		span = int'(win_len);
		if (span == 0)
			span = 1;
		if (span > MAX_WINDOW)
			span = MAX_WINDOW;
		ext = {s[SAMPLE_WIDTH-1], s};
		if (s[SAMPLE_WIDTH-1])
			ext = -ext;
		mag = SQ_W'(ext);
		sq = mag * mag;
		old = squares[slot];
		squares[slot] = sq;
		if (int'(slot) >= span - 1)
			slot = '0;
		else
			slot = slot + SLOT_W'(1);
		square_total = square_total + SUM_W'(sq) - SUM_W'(old);
		prod = PROD_W'(square_total);
		prod = prod * PROD_W'(recip);
		prod = prod >> FRAC_W;
		mean = (prod > PROD_W'(OUT_MAX)) ? OUT_MAX : prod[OUT_W-1:0];
	endtask

	task automatic report(input string what, input logic [OUT_W-1:0] want,
			input logic [OUT_W-1:0] got);
		if (mismatches < 50)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [OUT_W-1:0] want;
		if (!arst_n) begin
			win_len = LEN_RESET;
			recip = RECIP_RESET;
			restart_window();
			awaited_means.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WINDOW_LENGTH) begin
					win_len = cfg_data[LEN_W-1:0];
					restart_window();
				end else if (cfg_index == REG_WINDOW_RECIPROCAL) begin
					recip = cfg_data[RECIP_W-1:0];
				end
			end
			if (in_valid && !in_stall) begin
				step_window(sample, want);
				awaited_means.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (awaited_means.size() == 0) begin
					report("unexpected result", '0, mean_square);
				end else begin
					want = awaited_means.pop_front();
					if (mean_square !== want)
						report("mean_square", want, mean_square);
				end
			end
			outstanding <= awaited_means.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for moving_mean_square_top: clock, reset, register phases and
// sample stimulus with random gaps and stalls; checking lives in mean_square_monitor.
// Depends on mms_pkg, the block's RTL and mean_square_monitor.
module tb;
	import mms_pkg::*;

	localparam int SAMPLE_W = 16;
	localparam int LIMIT    = 1_000_000;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] CORNERS [10] = '{
		16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001,
		16'sh5555, 16'shAAAA, 16'sh8000, 16'sh8000, 16'sh7FFF
	};

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       out_valid;
	logic                       out_stall;
	logic [OUT_W-1:0]           mean_square;
	int                         mismatches;
	int                         outstanding;
	int                         cycles = 0;
	bit                         quiet;

	moving_mean_square_top DUT (.*);

	mean_square_monitor monitor (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		logic signed [SAMPLE_W-1:0] tiny;
		tiny = SAMPLE_W'($urandom_range(0, 15));
		case ($urandom_range(0, 9))
			0: return S_MIN;
			1: return S_MAX;
			2: return $urandom_range(0, 1) ? tiny : -tiny;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic push_sample(input logic signed [SAMPLE_W-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_window(input int len, input int rcp);
		logic [CFG_W-LEN_W-1:0] junk;
		junk = $urandom_range(0, 1) ? (CFG_W-LEN_W)'($urandom) : '0;
		write_reg(REG_WINDOW_LENGTH, {junk, LEN_W'(len)});
		write_reg(REG_WINDOW_RECIPROCAL, CFG_W'(rcp));
	endtask

	task automatic run_samples(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			push_sample(pick_sample());
		end
	endtask

	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		int len;
		int span;
		int rcp;
		quiet = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_WINDOW_LENGTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sample <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: full window, reciprocal 64
		foreach (CORNERS[i])
			push_sample(CORNERS[i]);
		drain();

		// oversized reciprocal, saturate
		set_window(2, 'h1FFFF);
		push_sample(S_MIN);
		push_sample(S_MIN);
		push_sample(S_MAX);
		push_sample(SAMPLE_W'(-1));
		drain();

		// zero reciprocal, keep ring
		write_reg(REG_WINDOW_RECIPROCAL, '0);
		push_sample(S_MIN);
		push_sample(S_MAX);
		drain();

		// zero length acts as one
		set_window(0, 65536);
		push_sample(S_MIN);
		push_sample(SAMPLE_W'(7));
		push_sample(S_MAX);
		drain();

		// length beyond depth, writes to unused indexes
		set_window(2047, 64);
		write_reg(REG_SPARE_A, CFG_W'($urandom));
		write_reg(REG_SPARE_B, CFG_W'($urandom));
		push_sample(S_MIN);
		push_sample(S_MAX);
		push_sample(SAMPLE_W'(1));
		drain();

		// full window, wraps the ring
		set_window(1024, 64);
		run_samples(600);
		drain();
		write_reg(REG_WINDOW_RECIPROCAL, CFG_W'($urandom_range(0, 'h1FFFF)));
		run_samples(450);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 7))
				0: len = 1;
				1: len = 2;
				2: len = $urandom_range(3, 16);
				3: len = $urandom_range(17, 1024);
				4: len = 1024;
				5: len = 0;
				6: len = $urandom_range(1025, 2047);
				default: len = $urandom_range(1, 64);
			endcase
			span = (len == 0) ? 1 : (len > 1024) ? 1024 : len;
			case ($urandom_range(0, 4))
				0: rcp = 65536 / span;
				1: rcp = $urandom_range(0, 'h1FFFF);
				2: rcp = 'h1FFFF;
				3: rcp = 0;
				default: rcp = 65536 / span + $urandom_range(0, 3);
			endcase
			set_window(len, rcp);
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
			run_samples($urandom_range(8, 40));
			if ($urandom_range(0, 2) == 0) begin
				drain();
				write_reg(REG_WINDOW_RECIPROCAL, CFG_W'($urandom_range(0, 'h1FFFF)));
				run_samples($urandom_range(4, 20));
			end
			drain();
		end

		@(negedge clk);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/mms_pkg.sv
rtl/mms_window.sv
rtl/mms_scale.sv
rtl/moving_mean_square_top.sv
rtl/moving_mean_square_chk.sv
sim/mean_square_monitor.sv
sim/tb.sv
